@@ src/mclg_pkg.sv @@
// mclg_pkg: shared types and codes of the mip chain layout generator
// used by the level unit, the top level and the bench
`default_nettype none

package mclg_pkg;

	localparam int unsigned MAX_MIPS = 15;

	// register indexes of the configuration port
	localparam logic [2:0] REG_BASE_WIDTH   = 3'd0;
	localparam logic [2:0] REG_BASE_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_MIP_LEVELS   = 3'd2;
	localparam logic [2:0] REG_FORMAT_CLASS = 3'd3;
	localparam logic [2:0] REG_DATA_START   = 3'd4;
	localparam logic [2:0] REG_FILE_LENGTH  = 3'd5;

	// format classes
	localparam logic [1:0] FMT_BLOCK8  = 2'd0;
	localparam logic [1:0] FMT_BLOCK16 = 2'd1;
	localparam logic [1:0] FMT_RGBA32  = 2'd2;
	localparam logic [1:0] FMT_NONE    = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_PAST_END    = 2'd1;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

	localparam logic [14:0] DIM_MAX = 15'd16384;

	// sizes of one mip level, produced by the level unit
	typedef struct packed {
		logic [14:0] width;
		logic [14:0] height;
		logic [16:0] row_bytes;
		logic [30:0] level_bytes;
	} level_t;

	// one result item as held in the output register
	typedef struct packed {
		logic [2:0]  slice_out;
		logic [3:0]  mip_number;
		logic [14:0] level_width;
		logic [14:0] level_height;
		logic [16:0] row_bytes;
		logic [30:0] level_bytes;
		logic [31:0] level_offset;
		logic [1:0]  status;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

@@ src/mclg_if.sv @@
// mclg channel interfaces: input items, result items and configuration writes
// valid/ready handshake on each; no dependencies
`default_nettype none

interface mclg_in_if;
	logic       valid;
	logic       ready;
	logic       restart;
	logic [2:0] slice_number;

	modport source (output valid, output restart, output slice_number, input ready);
	modport sink (input valid, input restart, input slice_number, output ready);
endinterface

interface mclg_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  slice_out;
	logic [3:0]  mip_number;
	logic [14:0] level_width;
	logic [14:0] level_height;
	logic [16:0] row_bytes;
	logic [30:0] level_bytes;
	logic [31:0] level_offset;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, output slice_out, output mip_number, output level_width,
		output level_height, output row_bytes, output level_bytes, output level_offset,
		output status, output last, input ready);
	modport sink (input valid, input slice_out, input mip_number, input level_width,
		input level_height, input row_bytes, input level_bytes, input level_offset,
		input status, input last, output ready);
endinterface

interface mclg_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/mclg_level_calc.sv @@
// mclg_level_calc: sizes of one mip level and the shared multiplier for its byte count
// depends on mclg_pkg; result registered in the cycle after the mip index is presented
`default_nettype none

module mclg_level_calc (
	input  wire logic            clk,
	input  wire logic [3:0]      mip,
	input  wire logic [14:0]     base_width,
	input  wire logic [14:0]     base_height,
	input  wire logic [1:0]      format_class,
	output mclg_pkg::level_t     level
);

	logic [14:0] w_sh;
	logic [14:0] h_sh;
	logic [14:0] w;
	logic [14:0] h;
	logic [14:0] w_p3;
	logic [14:0] h_p3;
	logic [12:0] blocks_x;
	logic [12:0] blocks_y;
	logic [16:0] row;
	logic [14:0] mul_b;
	logic [30:0] product;
	mclg_pkg::level_t level_q;

	always_comb begin
		w_sh = base_width >> mip;
		h_sh = base_height >> mip;
		w = (w_sh == 15'd0) ? 15'd1 : w_sh;
		h = (h_sh == 15'd0) ? 15'd1 : h_sh;
		// round up to whole 4x4 blocks, never zero since w and h are at least 1
		w_p3 = w + 15'd3;
		h_p3 = h + 15'd3;
		blocks_x = w_p3[14:2];
		blocks_y = h_p3[14:2];
		unique case (format_class)
			mclg_pkg::FMT_BLOCK8: begin
				row = {1'b0, blocks_x, 3'b000};
				mul_b = {2'b00, blocks_y};
			end
			mclg_pkg::FMT_BLOCK16: begin
				row = {blocks_x, 4'b0000};
				mul_b = {2'b00, blocks_y};
			end
			mclg_pkg::FMT_RGBA32: begin
				row = {w, 2'b00};
				mul_b = h;
			end
			default: begin
				row = 17'd0;
				mul_b = 15'd0;
			end
		endcase
		// at most 65536 * 16384, fits in 31 bits
		product = {14'd0, row} * {16'd0, mul_b};
	end

	always_ff @(posedge clk) begin
		level_q.width <= w;
		level_q.height <= h;
		level_q.row_bytes <= row;
		level_q.level_bytes <= product;
	end

	assign level = level_q;

endmodule

`default_nettype wire

@@ src/mip_chain_layout_generator_core.sv @@
// mip_chain_layout_generator_core: top level, configuration registers and mip sequencer
// depends on mclg_pkg, mclg_if and mclg_level_calc
`default_nettype none

// Each input item walks the mip chain of one texture slice and gives one result item
// per level: size, row pitch, slice pitch and file offset, with a running offset that
// carries from slice to slice until an item with restart set. One multiplier is shared
// by all levels under a small sequencer: an accepted item passes a head state, then
// each level a multiply state (level sizes, multiply) and a check state (bounds check,
// output register) that waits while the result side stalls. The input is not ready
// while an item is being walked. A level that runs past the end of the file ends the
// walk and sets a sticky error; format class 3 gives a single unsupported result.
// Users write configuration only while the block is idle; the block does not enforce it.

module mip_chain_layout_generator_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mclg_in_if.sink     req,
	mclg_out_if.source  rsp,
	mclg_cfg_if.sink    cfg
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_HEAD,
		S_MUL,
		S_CHK
	} state_t;

	state_t state_q;

	logic [14:0] base_width_q;
	logic [14:0] base_height_q;
	logic [3:0]  mip_levels_q;
	logic [1:0]  format_class_q;
	logic [7:0]  data_start_q;
	logic [31:0] file_length_q;

	logic [31:0] off_q;
	logic        failed_q;
	logic [3:0]  mip_q;
	logic [2:0]  slice_q;
	logic        out_valid_q;
	mclg_pkg::result_t res_q;

	logic [14:0] bw;
	logic [14:0] bh;
	logic [3:0]  last_mip;
	logic        slot_free;
	logic        out_load;
	logic        in_accept;
	logic [32:0] end_sum;
	logic        past_end;
	mclg_pkg::level_t level;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_width_q <= 15'd1;
			base_height_q <= 15'd1;
			mip_levels_q <= 4'd1;
			format_class_q <= mclg_pkg::FMT_RGBA32;
			data_start_q <= 8'd128;
			file_length_q <= 32'd0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				mclg_pkg::REG_BASE_WIDTH:   base_width_q <= cfg.data[14:0];
				mclg_pkg::REG_BASE_HEIGHT:  base_height_q <= cfg.data[14:0];
				mclg_pkg::REG_MIP_LEVELS:   mip_levels_q <= cfg.data[3:0];
				mclg_pkg::REG_FORMAT_CLASS: format_class_q <= cfg.data[1:0];
				mclg_pkg::REG_DATA_START:   data_start_q <= cfg.data[7:0];
				mclg_pkg::REG_FILE_LENGTH:  file_length_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (base_width_q == 15'd0) bw = 15'd1;
		else if (base_width_q > mclg_pkg::DIM_MAX) bw = mclg_pkg::DIM_MAX;
		else bw = base_width_q;
		if (base_height_q == 15'd0) bh = 15'd1;
		else if (base_height_q > mclg_pkg::DIM_MAX) bh = mclg_pkg::DIM_MAX;
		else bh = base_height_q;
		if (mip_levels_q == 4'd0) last_mip = 4'd0;
		else if (32'(mip_levels_q) > mclg_pkg::MAX_MIPS) last_mip = 4'(mclg_pkg::MAX_MIPS - 1);
		else last_mip = mip_levels_q - 4'd1;
	end

	mclg_level_calc u_level (
		.clk          (clk),
		.mip          (mip_q),
		.base_width   (bw),
		.base_height  (bh),
		.format_class (format_class_q),
		.level        (level)
	);

	assign req.ready = (state_q == S_IDLE);
	assign in_accept = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign end_sum = {1'b0, off_q} + {2'b00, level.level_bytes};
	assign past_end = end_sum > {1'b0, file_length_q};
	// a result is loaded into the output register this cycle
	assign out_load = slot_free && ((state_q == S_CHK) || ((state_q == S_HEAD) &&
		(format_class_q == mclg_pkg::FMT_NONE || failed_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			off_q <= 32'd128;
			failed_q <= 1'b0;
			mip_q <= 4'd0;
			slice_q <= 3'd0;
			out_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						slice_q <= req.slice_number;
						mip_q <= 4'd0;
						if (req.restart) begin
							off_q <= {24'd0, data_start_q};
							failed_q <= 1'b0;
						end
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					if (format_class_q == mclg_pkg::FMT_NONE || failed_q) begin
						if (slot_free) begin
							res_q.slice_out <= slice_q;
							res_q.mip_number <= 4'd0;
							res_q.level_width <= bw;
							res_q.level_height <= bh;
							res_q.row_bytes <= 17'd0;
							res_q.level_bytes <= 31'd0;
							res_q.level_offset <= off_q;
							res_q.status <= (format_class_q == mclg_pkg::FMT_NONE) ?
								mclg_pkg::ST_UNSUPPORTED : mclg_pkg::ST_PAST_END;
							res_q.last <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					// level unit registers sizes and product at this edge
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (slot_free) begin
						res_q.slice_out <= slice_q;
						res_q.mip_number <= mip_q;
						res_q.level_width <= level.width;
						res_q.level_height <= level.height;
						res_q.row_bytes <= level.row_bytes;
						res_q.level_bytes <= level.level_bytes;
						res_q.level_offset <= off_q;
						if (past_end) begin
							res_q.status <= mclg_pkg::ST_PAST_END;
							res_q.last <= 1'b1;
							failed_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							res_q.status <= mclg_pkg::ST_OK;
							res_q.last <= (mip_q == last_mip);
							off_q <= end_sum[31:0];
							if (mip_q == last_mip) begin
								state_q <= S_IDLE;
							end else begin
								mip_q <= mip_q + 4'd1;
								state_q <= S_MUL;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.slice_out = res_q.slice_out;
	assign rsp.mip_number = res_q.mip_number;
	assign rsp.level_width = res_q.level_width;
	assign rsp.level_height = res_q.level_height;
	assign rsp.row_bytes = res_q.row_bytes;
	assign rsp.level_bytes = res_q.level_bytes;
	assign rsp.level_offset = res_q.level_offset;
	assign rsp.status = res_q.status;
	assign rsp.last = res_q.last;

	// a result that is not the last of its item means the walk is still going
	a_busy_until_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.last |-> state_q != S_IDLE)
		else $error("non-final result pending while sequencer idle");

	// the sticky error is only ever set together with a past-end result
	a_fail_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(failed_q) |-> out_valid_q && res_q.last && res_q.status == mclg_pkg::ST_PAST_END)
		else $error("error flag set without a past-end result");

	// the running offset only moves on an accepted item or an in-bounds level
	a_offset_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(off_q) |-> $past(in_accept) || ($past(state_q == S_CHK) && !$past(past_end)))
		else $error("running offset changed outside a level step or restart");

endmodule

`default_nettype wire

@@ tb/tb_mip_chain_layout_generator_core.sv @@
// tb_mip_chain_layout_generator_core: self-checking bench for the mip chain layout generator
// predicts every level result from its own layout model and compares field by field
// depends on mclg_pkg, mclg_if and mip_chain_layout_generator_core
`default_nettype none

module tb_mip_chain_layout_generator_core;
	import mclg_pkg::*;

	typedef struct {
		logic       restart;
		logic [2:0] slice;
	} slice_req_t;

	logic clk;
	logic arst_n;

	mclg_in_if  slice_ch ();
	mclg_out_if level_ch ();
	mclg_cfg_if cfg_ch ();

	mip_chain_layout_generator_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (slice_ch),
		.rsp    (level_ch),
		.cfg    (cfg_ch)
	);

	slice_req_t slices_to_send[$];
	result_t    queued_levels[$];
	int         mismatch_count = 0;
	int         send_idle_pct = 27;
	int         recv_idle_pct = 55;

	// long receiver hold-off
	logic hold_go = 1'b0;
	logic hold_seen;
	int   hold_left;

	// shadow registers and layout state
	logic [14:0] cfg_width = 15'd1;
	logic [14:0] cfg_height = 15'd1;
	logic [3:0]  cfg_mips = 4'd1;
	logic [1:0]  cfg_format = FMT_RGBA32;
	logic [7:0]  cfg_start = 8'd128;
	logic [31:0] cfg_file_len = 32'd0;
	logic [32:0] run_offset = 33'd128;
	logic        walk_failed = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [14:0] clamp_size(input logic [14:0] v);
		if (v == 15'd0)
			return 15'd1;
		if (v > DIM_MAX)
			return DIM_MAX;
		return v;
	endfunction

	function automatic void push_level(input logic [2:0] slice, input logic [3:0] mip,
		input logic [14:0] w, input logic [14:0] h, input logic [16:0] row,
		input logic [30:0] lvl, input logic [1:0] st, input logic last_flag);
		result_t r;
		r.slice_out    = slice;
		r.mip_number   = mip;
		r.level_width  = w;
		r.level_height = h;
		r.row_bytes    = row;
		r.level_bytes  = lvl;
		r.level_offset = run_offset[31:0];
		r.status       = st;
		r.last         = last_flag;
		queued_levels.insert(queued_levels.size(), r);
	endfunction

	// walk the mip chain of one slice and queue the levels it should produce
	function automatic void lay_out_slice(input logic do_restart, input logic [2:0] slice);
		logic [14:0] bw, bh, w, h;
		logic [16:0] row;
		logic [30:0] lvl;
		logic [13:0] bx, by;
		int unsigned count;
		int m;
		bw = clamp_size(cfg_width);
		bh = clamp_size(cfg_height);
		if (do_restart) begin
			run_offset  = 33'(cfg_start);
			walk_failed = 1'b0;
		end
		if (cfg_format == FMT_NONE) begin
			push_level(slice, 4'd0, bw, bh, 17'd0, 31'd0, ST_UNSUPPORTED, 1'b1);
			return;
		end
		if (walk_failed) begin
			push_level(slice, 4'd0, bw, bh, 17'd0, 31'd0, ST_PAST_END, 1'b1);
			return;
		end
		count = (cfg_mips == 4'd0) ? 1 : cfg_mips;
		if (count > MAX_MIPS)
			count = MAX_MIPS;
		for (m = 0; m < count; m++) begin
			w = bw >> m;
			h = bh >> m;
			if (w == 15'd0)
				w = 15'd1;
			if (h == 15'd0)
				h = 15'd1;
			if (cfg_format == FMT_RGBA32) begin
				row = {w, 2'b00};
				lvl = 31'(32'(row) * 32'(h));
			end else begin
				bx  = 14'((17'(w) + 17'd3) >> 2);
				by  = 14'((17'(h) + 17'd3) >> 2);
				row = 17'(bx) * ((cfg_format == FMT_BLOCK8) ? 17'd8 : 17'd16);
				lvl = 31'(32'(row) * 32'(by));
			end
			if (34'(run_offset) + 34'(lvl) > 34'(cfg_file_len)) begin
				push_level(slice, 4'(m), w, h, row, lvl, ST_PAST_END, 1'b1);
				walk_failed = 1'b1;
				return;
			end
			push_level(slice, 4'(m), w, h, row, lvl, ST_OK, (m + 1 == count));
			run_offset = run_offset + 33'(lvl);
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("%0t mismatch: %s", $time, what);
	endtask

	function automatic string field_note(input string name, input logic [63:0] got,
		input logic [63:0] want);
		return $sformatf("%s got %0d expected %0d", name, got, want);
	endfunction

	task automatic check_level(input result_t got);
		result_t want;
		string   tag;
		if (queued_levels.size() == 0) begin
			report_mismatch($sformatf("level slice %0d mip %0d with none expected",
				got.slice_out, got.mip_number));
			return;
		end
		want = queued_levels.pop_front();
		tag  = $sformatf("slice %0d mip %0d ", want.slice_out, want.mip_number);
		if (got.slice_out !== want.slice_out)
			report_mismatch({tag, field_note("slice_out", got.slice_out, want.slice_out)});
		if (got.mip_number !== want.mip_number)
			report_mismatch({tag, field_note("mip_number", got.mip_number, want.mip_number)});
		if (got.level_width !== want.level_width)
			report_mismatch({tag, field_note("level_width", got.level_width, want.level_width)});
		if (got.level_height !== want.level_height)
			report_mismatch({tag, field_note("level_height", got.level_height,
				want.level_height)});
		if (got.row_bytes !== want.row_bytes)
			report_mismatch({tag, field_note("row_bytes", got.row_bytes, want.row_bytes)});
		if (got.level_bytes !== want.level_bytes)
			report_mismatch({tag, field_note("level_bytes", got.level_bytes, want.level_bytes)});
		if (got.level_offset !== want.level_offset)
			report_mismatch({tag, field_note("level_offset", got.level_offset,
				want.level_offset)});
		if (got.status !== want.status)
			report_mismatch({tag, field_note("status", got.status, want.status)});
		if (got.last !== want.last)
			report_mismatch({tag, field_note("last", got.last, want.last)});
	endtask

	// slice item driver
	always @(posedge clk or negedge arst_n) begin : drive_slices
		slice_req_t head;
		if (!arst_n) begin
			slice_ch.valid        <= 1'b0;
			slice_ch.restart      <= 1'b0;
			slice_ch.slice_number <= 3'd0;
		end else if (!slice_ch.valid || slice_ch.ready) begin
			if (slices_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				head = slices_to_send.pop_front();
				slice_ch.valid        <= 1'b1;
				slice_ch.restart      <= head.restart;
				slice_ch.slice_number <= head.slice;
			end else begin
				slice_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= 1'b0;
		end else if (hold_go && !hold_seen) begin
			hold_left <= 300;
			hold_seen <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			level_ch.ready <= 1'b0;
		else
			level_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// monitor: register writes, accepted slices and accepted levels
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_BASE_WIDTH:   cfg_width = cfg_ch.data[14:0];
					REG_BASE_HEIGHT:  cfg_height = cfg_ch.data[14:0];
					REG_MIP_LEVELS:   cfg_mips = cfg_ch.data[3:0];
					REG_FORMAT_CLASS: cfg_format = cfg_ch.data[1:0];
					REG_DATA_START:   cfg_start = cfg_ch.data[7:0];
					REG_FILE_LENGTH:  cfg_file_len = cfg_ch.data;
					default: ;
				endcase
			end
			if (slice_ch.valid && slice_ch.ready)
				lay_out_slice(slice_ch.restart, slice_ch.slice_number);
			if (level_ch.valid && level_ch.ready)
				check_level({level_ch.slice_out, level_ch.mip_number, level_ch.level_width,
					level_ch.level_height, level_ch.row_bytes, level_ch.level_bytes,
					level_ch.level_offset, level_ch.status, level_ch.last});
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// wait until every slice is sent and every level is back, then let the walk settle
	task automatic drain();
		do @(negedge clk);
		while (slices_to_send.size() != 0 || slice_ch.valid || queued_levels.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic configure(input logic [14:0] w, input logic [14:0] h,
		input logic [3:0] mips, input logic [1:0] fmt, input logic [7:0] start,
		input logic [31:0] flen);
		drain();
		write_reg(REG_BASE_WIDTH, 32'(w));
		write_reg(REG_BASE_HEIGHT, 32'(h));
		write_reg(REG_MIP_LEVELS, 32'(mips));
		write_reg(REG_FORMAT_CLASS, 32'(fmt));
		write_reg(REG_DATA_START, 32'(start));
		write_reg(REG_FILE_LENGTH, flen);
		@(negedge clk);
	endtask

	function automatic void offer(input logic restart, input logic [2:0] slice);
		slice_req_t s;
		s.restart = restart;
		s.slice   = slice;
		slices_to_send.insert(slices_to_send.size(), s);
	endfunction

	function automatic logic [14:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 15'($urandom_range(0, 32767));
			1: return DIM_MAX;
			2: return 15'd0;
			default: return 15'($urandom_range(1, 48));
		endcase
	endfunction

	function automatic logic [31:0] pick_file_len();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'hFFFF_FFFF;
			default: return 32'($urandom_range(0, 60000));
		endcase
	endfunction

	initial begin : stimulus
		int p;
		int k;
		int n_items;
		logic [1:0] fmt;
		logic [7:0] start;
		arst_n       <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_BASE_WIDTH;
		cfg_ch.data  <= 32'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: a one pixel level never fits a zero length file, error sticks
		offer(1'b0, 3'd0);
		offer(1'b0, 3'd5);
		offer(1'b1, 3'd3);

		// full size chain: the third slice runs out of the 4 GB file mid-walk
		configure(DIM_MAX, DIM_MAX, 4'd15, FMT_RGBA32, 8'd148, 32'hFFFF_FFFF);
		offer(1'b1, 3'd5);
		offer(1'b0, 3'd0);
		offer(1'b0, 3'd1);
		offer(1'b0, 3'd2);
		offer(1'b1, 3'd4);

		// zero sizes and zero mip count
		configure(15'd0, 15'd0, 4'd0, FMT_BLOCK8, 8'd128, 32'd4096);
		offer(1'b1, 3'd0);
		offer(1'b0, 3'd1);

		// oversize width saturates
		configure(15'h7FFF, 15'd5, 4'd15, FMT_BLOCK16, 8'd131, 32'h8000_0000);
		offer(1'b1, 3'd2);
		offer(1'b0, 3'd3);

		configure(15'd7, 15'd9, 4'd4, FMT_NONE, 8'd128, 32'h0001_0000);
		offer(1'b0, 3'd1);
		offer(1'b1, 3'd4);

		// chain ends exactly at the file end, the next slice does not fit
		configure(15'd4, 15'd4, 4'd3, FMT_RGBA32, 8'd128, 32'd212);
		offer(1'b1, 3'd0);
		offer(1'b0, 3'd1);

		// new data start waits for a restart
		configure(15'd4, 15'd4, 4'd3, FMT_RGBA32, 8'd255, 32'd1000);
		offer(1'b0, 3'd2);
		offer(1'b1, 3'd3);

		for (p = 0; p < 12; p++) begin
			fmt   = ($urandom_range(0, 7) == 0) ? FMT_NONE : 2'($urandom_range(0, 2));
			start = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(128, 148));
			configure(pick_size(), pick_size(), 4'($urandom_range(0, 15)), fmt, start,
				pick_file_len());
			case (p / 4)
				0: begin
					send_idle_pct = 27;
					recv_idle_pct = 55;
				end
				1: begin
					send_idle_pct = 55;
					recv_idle_pct = 27;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			n_items = $urandom_range(6, 12);
			if (p == 0) begin
				// receiver holds off while slices keep coming
				hold_go = 1'b1;
				n_items = 20;
			end
			for (k = 0; k < n_items; k++)
				offer((k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0),
					3'($urandom_range(0, 5)));
		end

		drain();
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
src/mclg_pkg.sv
src/mclg_if.sv
src/mclg_level_calc.sv
src/mip_chain_layout_generator_core.sv
tb/tb_mip_chain_layout_generator_core.sv
